### sv/dme_pkg.sv
// Shared types, constants and a helper function of the DHCP message type extractor.
package dme_pkg;

	localparam int POSITION_WIDTH = 16;
	localparam int OPTIONS_START  = 240;
	localparam int COOKIE_START   = 236;
	localparam int CLIENT_START   = 12;
	localparam int OFFERED_START  = 16;

	localparam logic [7:0] OPT_PAD       = 8'h00;
	localparam logic [7:0] OPT_END       = 8'hFF;
	localparam logic [7:0] OPT_MSG_TYPE  = 8'd53;
	localparam logic [7:0] OP_BOOTREQUEST = 8'd1;

	typedef logic [POSITION_WIDTH-1:0] pos_t;

	typedef enum logic [1:0] {
		PH_CODE = 2'd0,
		PH_LEN  = 2'd1,
		PH_DATA = 2'd2,
		PH_DONE = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		ST_TRUNCATED = 2'd0,
		ST_NO_COOKIE = 2'd1,
		ST_DHCP_TYPE = 2'd2,
		ST_NO_TYPE   = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
	} beat_t;

	typedef struct packed {
		status_t     status;
		logic        is_request;
		logic [31:0] client_addr;
		logic [31:0] your_addr;
		logic [7:0]  message_type;
		logic [15:0] payload_length;
	} result_t;

	// Magic cookie byte for the given offset within the four cookie bytes.
	function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0: b = 8'h63;
			2'd1: b = 8'h82;
			2'd2: b = 8'h53;
			2'd3: b = 8'h63;
			default: b = 8'h63;
		endcase
		return b;
	endfunction

endpackage

### sv/dme_if.sv
// Valid/ready channel interfaces for payload bytes and parse results.
interface dme_in_if;
	import dme_pkg::*;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last;

	modport source (output valid, output data_byte, output last, input ready);
	modport sink (input valid, input data_byte, input last, output ready);
endinterface

interface dme_out_if;
	import dme_pkg::*;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic        is_request;
	logic [31:0] client_addr;
	logic [31:0] your_addr;
	logic [7:0]  message_type;
	logic [15:0] payload_length;

	modport source (output valid, output status, output is_request, output client_addr,
		output your_addr, output message_type, output payload_length, input ready);
	modport sink (input valid, input status, input is_request, input client_addr,
		input your_addr, input message_type, input payload_length, output ready);
endinterface

### sv/dhcp_message_type_extractor.sv
// Top level of the streaming DHCP message type extractor.
//
// Usage: in_beat carries a UDP application payload one byte per beat, with
// last set on the final byte. For every payload exactly one result beat
// leaves on out_beat: status, request flag, client and offered addresses,
// the DHCP message type and the payload length.
// Throughput: one byte per cycle, including back-to-back payloads, unless a last
// byte waits for an untaken result; a new payload may start in the cycle after the previous last byte.
// The edge that moves the last byte out of the input register also loads
// the result register, from which a ready receiver takes the result beat.
// Each byte passes through the input register, is parsed by short logic
// against the running state, and on the last byte the result is registered.
// Stall: while a result waits in the output register, further non-final
// bytes still flow into the parser; only a second final byte is held in
// the input register, and in_beat.ready drops once that register is full.
// Reset: arst_n clears both valid flags and returns the parse state to its
// start-of-payload values; no result is pending after reset.
module dhcp_message_type_extractor
	import dme_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	dme_in_if.sink    in_beat,
	dme_out_if.source out_beat
);

	logic    valid_s1;
	beat_t   beat_s1;
	logic    advance;
	logic    out_free;
	result_t result;

	// A byte leaves the input register unless it is a last byte that
	// would overwrite an untaken result.
	assign advance = valid_s1 && (!beat_s1.last || out_free);

	dme_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_beat  (in_beat),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.beat_s1  (beat_s1)
	);

	dme_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.beat_s1 (beat_s1),
		.result  (result)
	);

	dme_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && beat_s1.last),
		.result   (result),
		.free     (out_free),
		.out_beat (out_beat)
	);

endmodule

### sv/dme_in_reg.sv
// Input register stage holding one accepted payload byte.
module dme_in_reg
	import dme_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	dme_in_if.sink  in_beat,
	input  logic    advance,
	output logic    valid_s1,
	output beat_t   beat_s1
);

	assign in_beat.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_beat.ready) begin
			valid_s1 <= in_beat.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat.ready && in_beat.valid) begin
			beat_s1.data_byte <= in_beat.data_byte;
			beat_s1.last      <= in_beat.last;
		end
	end

endmodule

### sv/dme_parser.sv
// Per-payload parse state: position count, header capture, cookie check and option walk.
module dme_parser
	import dme_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    advance,
	input  beat_t   beat_s1,
	output result_t result
);

	pos_t        pos_q;
	logic        req_q;
	logic [31:0] client_q;
	logic [31:0] offered_q;
	logic        cookie_ok_q;
	phase_t      phase_q;
	logic [7:0]  code_q;
	logic [7:0]  left_q;
	logic [7:0]  type_q;

	pos_t        pos_d;
	logic        req_d;
	logic [31:0] client_d;
	logic [31:0] offered_d;
	logic        cookie_ok_d;
	phase_t      phase_d;
	logic [7:0]  code_d;
	logic [7:0]  left_d;
	logic [7:0]  type_d;

	logic [7:0]  b;
	logic        in_options;
	logic [31:0] count_ext;

	assign b          = beat_s1.data_byte;
	assign in_options = 32'(pos_q) >= 32'(OPTIONS_START);

	// Header fields and the position counter.
	always_comb begin
		req_d       = req_q;
		client_d    = client_q;
		offered_d   = offered_q;
		cookie_ok_d = cookie_ok_q;
		if (pos_q == '0) begin
			req_d = (b == OP_BOOTREQUEST);
		end
		if (32'(pos_q) >= 32'(CLIENT_START) && 32'(pos_q) < 32'(CLIENT_START + 4)) begin
			client_d = {client_q[23:0], b};
		end
		if (32'(pos_q) >= 32'(OFFERED_START) && 32'(pos_q) < 32'(OFFERED_START + 4)) begin
			offered_d = {offered_q[23:0], b};
		end
		if (32'(pos_q) >= 32'(COOKIE_START) && 32'(pos_q) < 32'(COOKIE_START + 4)) begin
			if (b != cookie_byte(pos_q[1:0])) begin
				cookie_ok_d = 1'b0;
			end
		end
		pos_d = (pos_q == '1) ? pos_q : pos_q + 1'b1;
	end

	// Option walk: next phase.
	always_comb begin
		phase_d = phase_q;
		if (in_options) begin
			case (phase_q)
				PH_CODE: begin
					if (b == OPT_END) begin
						phase_d = PH_DONE;
					end else if (b != OPT_PAD) begin
						phase_d = PH_LEN;
					end
				end
				PH_LEN:  phase_d = (b == 8'd0) ? PH_CODE : PH_DATA;
				PH_DATA: phase_d = (left_q == 8'd1) ? PH_CODE : PH_DATA;
				PH_DONE: phase_d = PH_DONE;
				default: phase_d = phase_q;
			endcase
		end
	end

	// Option walk: code, remaining length and captured type.
	always_comb begin
		code_d = code_q;
		left_d = left_q;
		type_d = type_q;
		if (in_options) begin
			case (phase_q)
				PH_CODE: begin
					if (b != OPT_END && b != OPT_PAD) begin
						code_d = b;
					end
				end
				PH_LEN: begin
					if (code_q == OPT_MSG_TYPE && b != 8'd1) begin
						code_d = 8'd0;
					end
					left_d = b;
				end
				PH_DATA: begin
					if (left_q == 8'd1 && code_q == OPT_MSG_TYPE) begin
						type_d = b;
					end
					left_d = left_q - 8'd1;
				end
				PH_DONE: ;
				default: ;
			endcase
		end
	end

	// Result as seen after this byte.
	assign count_ext = 32'(pos_d);

	always_comb begin
		result = '0;
		result.payload_length = (count_ext > 32'h0000_FFFF) ? 16'hFFFF : count_ext[15:0];
		if (count_ext < 32'(OPTIONS_START)) begin
			result.status = ST_TRUNCATED;
		end else begin
			result.is_request  = req_d;
			result.client_addr = client_d;
			result.your_addr   = offered_d;
			if (!cookie_ok_d) begin
				result.status = ST_NO_COOKIE;
			end else if (type_d != 8'd0) begin
				result.status       = ST_DHCP_TYPE;
				result.message_type = type_d;
			end else begin
				result.status = ST_NO_TYPE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			req_q       <= 1'b0;
			client_q    <= '0;
			offered_q   <= '0;
			cookie_ok_q <= 1'b1;
			phase_q     <= PH_CODE;
			code_q      <= '0;
			left_q      <= '0;
			type_q      <= '0;
		end else if (advance) begin
			if (beat_s1.last) begin
				pos_q       <= '0;
				req_q       <= 1'b0;
				client_q    <= '0;
				offered_q   <= '0;
				cookie_ok_q <= 1'b1;
				phase_q     <= PH_CODE;
				code_q      <= '0;
				left_q      <= '0;
				type_q      <= '0;
			end else begin
				pos_q       <= pos_d;
				req_q       <= req_d;
				client_q    <= client_d;
				offered_q   <= offered_d;
				cookie_ok_q <= cookie_ok_d;
				phase_q     <= phase_d;
				code_q      <= code_d;
				left_q      <= left_d;
				type_q      <= type_d;
			end
		end
	end

endmodule

### sv/dme_out_reg.sv
// Result register driving the output channel.
module dme_out_reg
	import dme_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  result_t   result,
	output logic      free,
	dme_out_if.source out_beat
);

	logic    valid_q;
	result_t res_q;

	assign free = !valid_q || out_beat.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			res_q <= result;
		end
	end

	assign out_beat.valid          = valid_q;
	assign out_beat.status         = res_q.status;
	assign out_beat.is_request     = res_q.is_request;
	assign out_beat.client_addr    = res_q.client_addr;
	assign out_beat.your_addr      = res_q.your_addr;
	assign out_beat.message_type   = res_q.message_type;
	assign out_beat.payload_length = res_q.payload_length;

endmodule
